// ----- sv/radix_table_with_two_way_hash_cache_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the radix table with two-way hash cache
// Immediate-implication and next-cycle-implication forms, clocked and gated.
// ----------------------------------------------------------------------------
`ifndef RADIX_TABLE_WITH_TWO_WAY_HASH_CACHE_TOP_DEFINES_SVH
`define RADIX_TABLE_WITH_TWO_WAY_HASH_CACHE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define RTHT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtht: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define RTHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtht: next-cycle check failed");

`endif

// ----- sv/rtht_pkg.sv -----
// ----------------------------------------------------------------------------
// rtht_pkg
// Shared field widths, parameter defaults and channel payload types.
// ----------------------------------------------------------------------------
package rtht_pkg;

   // Fixed field widths
   localparam int ADDR_W   = 64;
   localparam int HANDLE_W = 32;
   localparam int COUNT_W  = 32;
   localparam int LFSR_W   = 16;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

   // Parameter defaults
   localparam int DEF_LINE_BITS   = 4;
   localparam int DEF_PAGE_BITS   = 10;
   localparam int DEF_HASH_BITS   = 10;
   localparam int DEF_NODE_COUNT  = 64;
   localparam int DEF_HANDLE_BITS = 32;

   // Operation codes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_ADD    = 1'b1;

   typedef struct packed {
      logic                opcode;
      logic [ADDR_W-1:0]   address;
      logic [HANDLE_W-1:0] entry_handle;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [HANDLE_W-1:0] result_handle;
      logic                pool_full;
      logic [COUNT_W-1:0]  stored_count;
   } rsp_type;

endpackage

// ----- sv/rtht_req_if.sv -----
// ----------------------------------------------------------------------------
// rtht_req_if
// Request channel: valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
interface rtht_req_if import rtht_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- sv/rtht_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rtht_rsp_if
// Response channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface rtht_rsp_if import rtht_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- sv/rtht_ram.sv -----
// ----------------------------------------------------------------------------
// rtht_ram
// Single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module rtht_ram #(
   parameter int DEPTH     = 1024,
   parameter int WIDTH     = 32,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/radix_table_with_two_way_hash_cache_top.sv -----
// ----------------------------------------------------------------------------
// radix_table_with_two_way_hash_cache_top
// Radix page table of node slots with a two-choice hash cache in front.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                        | handshake
//  req     | in  | opcode, address, entry_handle                 | valid/ready
//  rsp     | out | found, result_handle, pool_full, stored_count | valid/ready
//
// Steps: a lookup reads both cache slots and, on a miss, walks the tree;
//   an add walks the tree, allocates a node per missing level (or flags
//   pool_full if too few are free), then writes the leaf.
//   Each tree level costs one read of the slot RAM and one evaluate step.
// Reset: a clearing pass over the deeper of the slot and cache RAMs
//   empties both; no item is taken until it ends.
// Stalls: the result sits in an output register; req is ready again once
//   the result is loaded, even while rsp is stalled.
// ----------------------------------------------------------------------------
`include "radix_table_with_two_way_hash_cache_top_defines.svh"

module radix_table_with_two_way_hash_cache_top import rtht_pkg::*; #(
   parameter int LINE_BITS   = DEF_LINE_BITS,
   parameter int PAGE_BITS   = DEF_PAGE_BITS,
   parameter int HASH_BITS   = DEF_HASH_BITS,
   parameter int NODE_COUNT  = DEF_NODE_COUNT,
   parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
   input  logic       clock,
   input  logic       reset,
   rtht_req_if.sink   req,
   rtht_rsp_if.source rsp
);

   // Derived sizes
   localparam int KEY_W      = ADDR_W - LINE_BITS;
   localparam int DEPTH      = (KEY_W + PAGE_BITS - 1) / PAGE_BITS;
   localparam int PATH_W     = DEPTH * PAGE_BITS;
   localparam int LVL_BITS   = $clog2(DEPTH);
   localparam int NODE_BITS  = $clog2(NODE_COUNT);
   localparam int NU_BITS    = $clog2(NODE_COUNT + 1);
   localparam int SLOT_ABITS = NODE_BITS + PAGE_BITS;
   localparam int SLOT_DEPTH = NODE_COUNT * (1 << PAGE_BITS);
   localparam int CACHE_LEN  = 1 << HASH_BITS;
   localparam int LINK_W     = (HANDLE_BITS > NODE_BITS) ? HANDLE_BITS : NODE_BITS;
   localparam int SLOT_W     = 1 + LINK_W;
   localparam int CACHE_W    = 1 + HANDLE_BITS + ADDR_W;
   localparam int CLR_DEPTH  = (SLOT_DEPTH > CACHE_LEN) ? SLOT_DEPTH : CACHE_LEN;
   localparam int CLR_BITS   = $clog2(CLR_DEPTH);
   localparam int CMP_W      = NU_BITS + LVL_BITS + 1;

   // State codes
   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_C1    = 4'd2;
   localparam logic [3:0] ST_C2    = 4'd3;
   localparam logic [3:0] ST_C3    = 4'd4;
   localparam logic [3:0] ST_WRD   = 4'd5;
   localparam logic [3:0] ST_WEV   = 4'd6;
   localparam logic [3:0] ST_ALLOC = 4'd7;
   localparam logic [3:0] ST_LEAF  = 4'd8;
   localparam logic [3:0] ST_RESP  = 4'd9;

   // Registers and next values
   logic [3:0]             state_ff,     state_in;
   logic [CLR_BITS-1:0]    clr_ff,       clr_in;
   logic                   op_ff,        op_in;
   logic [ADDR_W-1:0]      addr_ff,      addr_in;
   logic [HANDLE_BITS-1:0] hdl_ff,       hdl_in;
   logic [PATH_W-1:0]      path_ff,      path_in;
   logic [NODE_BITS-1:0]   node_ff,      node_in;
   logic [LVL_BITS-1:0]    lvl_ff,       lvl_in;
   logic [HASH_BITS-1:0]   h1_ff,        h1_in;
   logic                   c1_valid_ff,  c1_valid_in;
   logic [HANDLE_BITS-1:0] c1_hdl_ff,    c1_hdl_in;
   logic [ADDR_W-1:0]      c1_key_ff,    c1_key_in;
   logic                   c2_valid_ff,  c2_valid_in;
   logic                   found_ff,     found_in;
   logic [HANDLE_BITS-1:0] res_hdl_ff,   res_hdl_in;
   logic                   full_ff,      full_in;
   logic [NU_BITS-1:0]     nodes_used_ff, nodes_used_in;
   logic [COUNT_W-1:0]     add_count_ff, add_count_in;
   logic [LFSR_W-1:0]      lfsr_ff,      lfsr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff,  rsp_data_in;

   // RAM ports
   logic                   slot_we, slot_re;
   logic [SLOT_ABITS-1:0]  slot_waddr, slot_raddr;
   logic [SLOT_W-1:0]      slot_wdata, slot_q;
   logic                   leaf_we;
   logic [ADDR_W-1:0]      leaf_q;
   logic                   cache_we, cache_re;
   logic [HASH_BITS-1:0]   cache_waddr, cache_raddr;
   logic [CACHE_W-1:0]     cache_wdata, cache_q;

   // Decoded helpers
   logic [ADDR_W-1:0]      key_full;
   logic [PAGE_BITS-1:0]   idx;
   logic                   last_lvl;
   logic                   link_ok;
   logic                   cq_valid;
   logic [HANDLE_BITS-1:0] cq_hdl;
   logic [ADDR_W-1:0]      cq_key;
   logic [LVL_BITS-1:0]    need;
   logic [NU_BITS-1:0]     free_nodes;
   logic                   pool_short;
   logic                   req_fire;

   assign req_fire   = req.valid && req.ready;
   assign key_full   = req.data.address >> LINE_BITS;
   assign idx        = path_ff[PATH_W-1 -: PAGE_BITS];
   assign last_lvl   = (lvl_ff == LVL_BITS'(DEPTH - 1));
   assign link_ok    = slot_q[LINK_W] &&
                       ({1'b0, slot_q[LINK_W-1:0]} < (LINK_W + 1)'(NODE_COUNT));
   assign cq_valid   = cache_q[CACHE_W-1];
   assign cq_hdl     = cache_q[ADDR_W +: HANDLE_BITS];
   assign cq_key     = cache_q[ADDR_W-1:0];
   assign need       = LVL_BITS'(DEPTH - 1) - lvl_ff;
   assign free_nodes = NU_BITS'(NODE_COUNT) - nodes_used_ff;
   assign pool_short = (CMP_W'(need) > CMP_W'(free_nodes));

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   // Sequencer: probe cache, walk tree, allocate, write leaf, respond
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      hdl_in        = hdl_ff;
      path_in       = path_ff;
      node_in       = node_ff;
      lvl_in        = lvl_ff;
      h1_in         = h1_ff;
      c1_valid_in   = c1_valid_ff;
      c1_hdl_in     = c1_hdl_ff;
      c1_key_in     = c1_key_ff;
      c2_valid_in   = c2_valid_ff;
      found_in      = found_ff;
      res_hdl_in    = res_hdl_ff;
      full_in       = full_ff;
      nodes_used_in = nodes_used_ff;
      add_count_in  = add_count_ff;
      lfsr_in       = lfsr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_data_in   = rsp_data_ff;

      slot_we     = 1'b0;
      slot_waddr  = {node_ff, idx};
      slot_wdata  = '0;
      slot_re     = 1'b0;
      slot_raddr  = {node_ff, idx};
      leaf_we     = 1'b0;
      cache_we    = 1'b0;
      cache_waddr = h1_ff;
      cache_wdata = '0;
      cache_re    = 1'b0;
      cache_raddr = h1_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep both RAMs empty, one entry per cycle
            slot_we     = (32'(clr_ff) < SLOT_DEPTH);
            slot_waddr  = clr_ff[SLOT_ABITS-1:0];
            cache_we    = 1'b1;
            cache_waddr = clr_ff[HASH_BITS-1:0];
            clr_in      = clr_ff + CLR_BITS'(1);
            if (32'(clr_ff) == CLR_DEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // Latch item and start at the root
            if (req_fire) begin
               op_in    = req.data.opcode;
               addr_in  = req.data.address;
               hdl_in   = req.data.entry_handle[HANDLE_BITS-1:0];
               path_in  = PATH_W'(key_full);
               node_in  = '0;
               lvl_in   = '0;
               h1_in    = key_full[32 +: HASH_BITS] ^ key_full[0 +: HASH_BITS];
               found_in = 1'b0;
               res_hdl_in = '0;
               full_in  = 1'b0;
               state_in = (req.data.opcode == OP_ADD) ? ST_WRD : ST_C1;
            end
         end
         ST_C1: begin
            cache_re    = 1'b1;
            cache_raddr = h1_ff;
            state_in    = ST_C2;
         end
         ST_C2: begin
            // Hold first probe, read the alternate slot
            c1_valid_in = cq_valid;
            c1_hdl_in   = cq_hdl;
            c1_key_in   = cq_key;
            cache_re    = 1'b1;
            cache_raddr = ~h1_ff;
            state_in    = ST_C3;
         end
         ST_C3: begin
            c2_valid_in = cq_valid;
            if (c1_valid_ff) begin
               if (c1_key_ff == addr_ff) begin
                  found_in   = 1'b1;
                  res_hdl_in = c1_hdl_ff;
               end
            end else if (cq_valid && (cq_key == addr_ff)) begin
               found_in   = 1'b1;
               res_hdl_in = cq_hdl;
            end
            if (found_in) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_WRD;
            end
         end
         ST_WRD: begin
            slot_re  = 1'b1;
            state_in = ST_WEV;
         end
         ST_WEV: begin
            if (!last_lvl) begin
               if (link_ok) begin
                  // Advance one level down
                  node_in  = slot_q[NODE_BITS-1:0];
                  path_in  = path_ff << PAGE_BITS;
                  lvl_in   = lvl_ff + LVL_BITS'(1);
                  state_in = ST_WRD;
               end else if (op_ff == OP_LOOKUP) begin
                  state_in = ST_RESP;
               end else if (pool_short) begin
                  full_in  = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_ALLOC;
               end
            end else if (op_ff == OP_ADD) begin
               state_in = ST_LEAF;
            end else begin
               // Refill the cache with the leaf, empty or not
               cache_we = 1'b1;
               if (!c1_valid_ff) begin
                  cache_waddr = h1_ff;
               end else if (!c2_valid_ff) begin
                  cache_waddr = ~h1_ff;
               end else begin
                  lfsr_in = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5],
                             lfsr_ff[LFSR_W-1:1]};
                  cache_waddr = lfsr_ff[0] ? h1_ff : ~h1_ff;
               end
               if (slot_q[LINK_W]) begin
                  cache_wdata = {1'b1, slot_q[HANDLE_BITS-1:0], leaf_q};
                  found_in    = 1'b1;
                  res_hdl_in  = slot_q[HANDLE_BITS-1:0];
               end
               state_in = ST_RESP;
            end
         end
         ST_ALLOC: begin
            // Link a fresh node into the current one; at the leaf level, go write the leaf
            if (last_lvl) begin
               state_in = ST_LEAF;
            end else begin
               slot_we       = 1'b1;
               slot_wdata    = {1'b1, LINK_W'(nodes_used_ff[NODE_BITS-1:0])};
               node_in       = nodes_used_ff[NODE_BITS-1:0];
               nodes_used_in = nodes_used_ff + NU_BITS'(1);
               path_in       = path_ff << PAGE_BITS;
               lvl_in        = lvl_ff + LVL_BITS'(1);
            end
         end
         ST_LEAF: begin
            slot_we    = 1'b1;
            slot_wdata = {1'b1, LINK_W'(hdl_ff)};
            leaf_we    = 1'b1;
            if (add_count_ff != '1) begin
               add_count_in = add_count_ff + COUNT_W'(1);
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.found         = found_ff;
               rsp_data_in.result_handle = HANDLE_W'(res_hdl_ff);
               rsp_data_in.pool_full     = full_ff;
               rsp_data_in.stored_count  = add_count_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         nodes_used_ff <= NU_BITS'(1);
         add_count_ff  <= '0;
         lfsr_ff       <= LFSR_SEED;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         nodes_used_ff <= nodes_used_in;
         add_count_ff  <= add_count_in;
         lfsr_ff       <= lfsr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      hdl_ff      <= hdl_in;
      path_ff     <= path_in;
      node_ff     <= node_in;
      lvl_ff      <= lvl_in;
      h1_ff       <= h1_in;
      c1_valid_ff <= c1_valid_in;
      c1_hdl_ff   <= c1_hdl_in;
      c1_key_ff   <= c1_key_in;
      c2_valid_ff <= c2_valid_in;
      found_ff    <= found_in;
      res_hdl_ff  <= res_hdl_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Node slot links
   rtht_ram #(.DEPTH(SLOT_DEPTH), .WIDTH(SLOT_W), .ADDR_BITS(SLOT_ABITS)) u_slot (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_en   (slot_re),
      .rd_addr (slot_raddr),
      .rd_data (slot_q)
   );

   // Leaf address keys
   rtht_ram #(.DEPTH(SLOT_DEPTH), .WIDTH(ADDR_W), .ADDR_BITS(SLOT_ABITS)) u_leaf (
      .clock   (clock),
      .wr_en   (leaf_we),
      .wr_addr (slot_waddr),
      .wr_data (addr_ff),
      .rd_en   (slot_re),
      .rd_addr (slot_raddr),
      .rd_data (leaf_q)
   );

   // Hash cache
   rtht_ram #(.DEPTH(CACHE_LEN), .WIDTH(CACHE_W), .ADDR_BITS(HASH_BITS)) u_cache (
      .clock   (clock),
      .wr_en   (cache_we),
      .wr_addr (cache_waddr),
      .wr_data (cache_wdata),
      .rd_en   (cache_re),
      .rd_addr (cache_raddr),
      .rd_data (cache_q)
   );

   // Checks
   `RTHT_ASSERT_NEXT(a_one_item, clock, reset, req.valid && req.ready, !req.ready)
   `RTHT_ASSERT_SAME(a_pool_bound, clock, reset, 1'b1, nodes_used_ff <= NU_BITS'(NODE_COUNT))
   `RTHT_ASSERT_SAME(a_alloc_add, clock, reset, state_ff == ST_ALLOC, op_ff == OP_ADD)
   `RTHT_ASSERT_SAME(a_rsp_excl, clock, reset, rsp_valid_ff, !(rsp_data_ff.found && rsp_data_ff.pool_full))

endmodule

// ----- test/radix_table_with_two_way_hash_cache_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_table_with_two_way_hash_cache_top_tb
// Drives lookup and add items through the radix table, predicts each result
// with a local copy of the tree, the cache and the counters, and compares
// every result field by field. It covers directed corner cases, random
// traffic, pool exhaustion and long output stalls.
// ----------------------------------------------------------------------------
module radix_table_with_two_way_hash_cache_top_tb;
   import rtht_pkg::*;

   localparam int LINE_B    = DEF_LINE_BITS;
   localparam int PAGE_B    = DEF_PAGE_BITS;
   localparam int HASH_B    = DEF_HASH_BITS;
   localparam int NODES     = DEF_NODE_COUNT;
   localparam int DEPTH     = (64 - LINE_B + PAGE_B - 1) / PAGE_B;
   localparam int PAGE_N    = 1 << PAGE_B;
   localparam int CACHE_N   = 1 << HASH_B;
   localparam int IDLE_MAX  = 200000;
   localparam int RAND_ITEMS = 480;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rtht_req_if req_ch ();
   rtht_rsp_if rsp_ch ();

   radix_table_with_two_way_hash_cache_top uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow table state
   bit                    tree_valid [int];
   logic [HANDLE_W-1:0]   tree_link  [int];
   logic [ADDR_W-1:0]     tree_key   [int];
   bit                    hc_valid   [CACHE_N];
   logic [HANDLE_W-1:0]   hc_handle  [CACHE_N];
   logic [ADDR_W-1:0]     hc_key     [CACHE_N];
   int unsigned           pool_used;
   logic [COUNT_W-1:0]    adds_done;
   logic [LFSR_W-1:0]     victim_lfsr;

   rsp_type           pending_rsp [$];
   logic [ADDR_W-1:0] added_addrs [$];
   int                errors;
   int                burst_left;
   int                long_hold;
   int                idle_cycles;

   function automatic int unsigned page_index(logic [ADDR_W-1:0] k, int lvl);
      return int'((k >> ((DEPTH - lvl - 1) * PAGE_B)) & (PAGE_N - 1));
   endfunction

   // Step the replacement LFSR; return the bit shifted out
   function automatic bit victim_step();
      logic [LFSR_W-1:0] l;
      bit fb;
      l = victim_lfsr;
      fb = l[0] ^ l[2] ^ l[3] ^ l[5];
      victim_lfsr = {fb, l[LFSR_W-1:1]};
      return l[0];
   endfunction

   // Compute the result of one item and update the shadow state
   function automatic rsp_type table_apply(logic op, logic [ADDR_W-1:0] addr,
                                           logic [HANDLE_W-1:0] hnd);
      rsp_type r;
      logic [ADDR_W-1:0] k;
      int unsigned h1, h2, tgt, node, slot, have, need;
      bit ok, hit, v;
      logic [HANDLE_W-1:0] hv;
      k = addr >> LINE_B;
      r = '0;
      node = 0;
      if (op == OP_LOOKUP) begin
         h1 = int'(((k >> 32) ^ k) & (CACHE_N - 1));
         h2 = h1 ^ (CACHE_N - 1);
         hit = 1'b0;
         hv = '0;
         ok = 1'b1;
         if (hc_valid[h1]) begin
            if (hc_key[h1] == addr) begin
               hit = 1'b1;
               hv = hc_handle[h1];
            end
         end else if (hc_valid[h2] && hc_key[h2] == addr) begin
            hit = 1'b1;
            hv = hc_handle[h2];
         end
         if (!hit) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               slot = node * PAGE_N + page_index(k, i);
               if (!tree_valid.exists(slot) || tree_link[slot] >= NODES) begin
                  ok = 1'b0;
                  break;
               end
               node = tree_link[slot];
            end
            if (ok) begin
               slot = node * PAGE_N + int'(k & (PAGE_N - 1));
               v = tree_valid.exists(slot);
               if (!hc_valid[h1]) tgt = h1;
               else if (!hc_valid[h2]) tgt = h2;
               else tgt = victim_step() ? h1 : h2;
               hc_valid[tgt] = v;
               hc_handle[tgt] = v ? tree_link[slot] : '0;
               hc_key[tgt] = v ? tree_key[slot] : '0;
               if (v) begin
                  hit = 1'b1;
                  hv = tree_link[slot];
               end
            end
         end
         r.found = hit;
         r.result_handle = hit ? hv : '0;
      end else begin
         have = 0;
         for (int i = 0; i < DEPTH - 1; i++) begin
            slot = node * PAGE_N + page_index(k, i);
            if (!tree_valid.exists(slot) || tree_link[slot] >= NODES) break;
            node = tree_link[slot];
            have++;
         end
         need = DEPTH - 1 - have;
         if (pool_used > NODES || need > NODES - pool_used) begin
            r.pool_full = 1'b1;
         end else begin
            // Fresh nodes were never used, so their slots are already empty
            for (int i = have; i < DEPTH - 1; i++) begin
               slot = node * PAGE_N + page_index(k, i);
               tree_valid[slot] = 1'b1;
               tree_link[slot] = pool_used;
               node = pool_used;
               pool_used++;
            end
            slot = node * PAGE_N + int'(k & (PAGE_N - 1));
            tree_valid[slot] = 1'b1;
            tree_link[slot] = hnd;
            tree_key[slot] = addr;
            if (adds_done != '1) adds_done++;
            added_addrs.push_back(addr);
         end
      end
      r.stored_count = adds_done;
      return r;
   endfunction

   // Offer one item, hold it until taken, then close the burst if it is over
   task automatic send_item(logic op, logic [ADDR_W-1:0] addr,
                            logic [HANDLE_W-1:0] hnd);
      req_type it;
      it.opcode = op;
      it.address = addr;
      it.entry_handle = hnd;
      req_ch.valid <= 1'b1;
      req_ch.data <= it;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_rsp.push_back(table_apply(op, addr, hnd));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
      end
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (pending_rsp.size() == 0) begin
            report("unexpected result", 64'(got), 64'(0));
         end else begin
            want = pending_rsp.pop_front();
            if (got.found !== want.found)
               report("found", 64'(got.found), 64'(want.found));
            if (got.result_handle !== want.result_handle)
               report("result_handle", 64'(got.result_handle), 64'(want.result_handle));
            if (got.pool_full !== want.pool_full)
               report("pool_full", 64'(got.pool_full), 64'(want.pool_full));
            if (got.stored_count !== want.stored_count)
               report("stored_count", 64'(got.stored_count), 64'(want.stored_count));
         end
      end
   end

   // Result stall pattern: free, light and heavy segments plus long holds
   always @(posedge clock) begin
      int seg_left;
      int seg_mode;
      if (long_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         long_hold--;
      end else begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(1, 40);
            seg_mode = $urandom_range(0, 2);
         end
         seg_left--;
         case (seg_mode)
            0: begin
               rsp_ch.ready <= 1'b1;
            end
            1: begin
               rsp_ch.ready <= ($urandom_range(0, 9) >= 3);
            end
            default: begin
               rsp_ch.ready <= ($urandom_range(0, 9) >= 7);
            end
         endcase
      end
   end

   // Watchdog on cycles with no item moving
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_MAX) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Directed corners: empty table, extreme keys, overwrite, empty leaf refill
   task automatic test_directed();
      send_item(OP_LOOKUP, 64'h0, 32'h0);
      send_item(OP_ADD, 64'h0, 32'hFFFF_FFFF);
      send_item(OP_LOOKUP, 64'h0, 32'h0);
      send_item(OP_LOOKUP, 64'h0, 32'h0);
      send_item(OP_LOOKUP, 64'hF, 32'h0);
      send_item(OP_LOOKUP, 64'h10, 32'h0);
      send_item(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
      send_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFF0, 32'h0);
      send_item(OP_ADD, 64'h0, 32'h1234_5678);
      send_item(OP_LOOKUP, 64'h0, 32'h0);
      send_item(OP_ADD, 64'h20, 32'hA5A5_5A5A);
      send_item(OP_LOOKUP, 64'h20, 32'h0);
      send_item(OP_LOOKUP, 64'h8000_0000_0000_0000, 32'h0);
      send_item(OP_ADD, 64'h5555_5555_5555_5555, 32'h5555_5555);
      send_item(OP_LOOKUP, 64'h5555_5555_5555_5555, 32'h0);
      send_item(OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
      send_item(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0);
   endtask

   // Random traffic around a few shared regions, with stray keys to drain the pool
   task automatic test_random(int count);
      logic [63:0] regions [4];
      logic [63:0] a;
      int pick;
      for (int i = 0; i < 4; i++) regions[i] = rand64() & ~64'h00FF_FFF0;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         a = regions[$urandom_range(0, 3)] | (64'($urandom) & 64'h00FF_FFFF);
         if (pick < 30) begin
            send_item(OP_ADD, a, $urandom);
         end else if (pick < 38) begin
            send_item(OP_ADD, rand64(), $urandom);
         end else if (pick < 75 && added_addrs.size() > 0) begin
            a = added_addrs[$urandom_range(0, added_addrs.size() - 1)];
            if ($urandom_range(0, 4) == 0) a[3:0] = 4'($urandom);
            send_item(OP_LOOKUP, a, $urandom);
         end else if (pick < 92) begin
            send_item(OP_LOOKUP, a, $urandom);
         end else begin
            send_item(OP_LOOKUP, rand64(), $urandom);
         end
      end
   endtask

   // Hold the result side off while items keep coming, so the input stalls
   task automatic test_backpressure();
      long_hold = 400;
      burst_left = 20;
      test_random(20);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      errors = 0;
      burst_left = 0;
      long_hold = 0;
      idle_cycles = 0;
      pool_used = 1;
      adds_done = '0;
      victim_lfsr = LFSR_SEED;
      for (int i = 0; i < CACHE_N; i++) begin
         hc_valid[i] = 1'b0;
         hc_handle[i] = '0;
         hc_key[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(RAND_ITEMS);
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/rtht_pkg.sv
sv/rtht_req_if.sv
sv/rtht_rsp_if.sv
sv/rtht_ram.sv
sv/radix_table_with_two_way_hash_cache_top.sv
test/radix_table_with_two_way_hash_cache_top_tb.sv
